@@ src/lrx_pkg.sv @@
`timescale 1ns / 1ps
// lrx_pkg: shared types and constants for the crlf line receiver
// used by lrx_mem and crlf_line_receiver_two_slot; no dependencies
package lrx_pkg;

    localparam int LINE_DEPTH = 256;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int PKT_AW     = LINE_AW + 1;

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    localparam logic [LINE_AW-1:0] LINE_LAST = LINE_AW'(LINE_DEPTH - 1);

    typedef enum logic [1:0] {
        OP_RX      = 2'd0,
        OP_RELEASE = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } lrx_op_t;

    typedef enum logic [1:0] {
        SLOT_NONE = 2'd0,
        SLOT_A    = 2'd1,
        SLOT_B    = 2'd2
    } lrx_slot_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY,
        ST_RD_WAIT,
        ST_EMIT
    } lrx_state_t;

    // memory port controls from the sequencer
    typedef struct packed {
        logic               line_we;
        logic [LINE_AW-1:0] line_waddr;
        logic [7:0]         line_wdata;
        logic               line_re;
        logic [LINE_AW-1:0] line_raddr;
        logic               pkt_we;
        logic [PKT_AW-1:0]  pkt_waddr;
        logic               pkt_re;
        logic [PKT_AW-1:0]  pkt_raddr;
    } lrx_mem_ctrl_t;

endpackage

@@ src/lrx_mem.sv @@
`timescale 1ns / 1ps
// lrx_mem: line buffer and two-slot packet store, both synchronous memories
// depends on lrx_pkg
module lrx_mem (
    input  logic                  clk,
    input  lrx_pkg::lrx_mem_ctrl_t ctrl,
    output logic [7:0]            pkt_rdata
);
    import lrx_pkg::*;

    logic [7:0] line_mem [LINE_DEPTH];
    logic [7:0] pkt_mem  [2*LINE_DEPTH];

    logic [7:0] line_rd_reg;
    logic [7:0] pkt_rd_reg;

    // line buffer: one write, one read port
    always_ff @(posedge clk)
    begin
        if (ctrl.line_we)
        begin
            line_mem[ctrl.line_waddr] <= ctrl.line_wdata;
        end
        if (ctrl.line_re)
        begin
            line_rd_reg <= line_mem[ctrl.line_raddr];
        end
    end

    // packet store: copy data comes straight from the line read register
    always_ff @(posedge clk)
    begin
        if (ctrl.pkt_we)
        begin
            pkt_mem[ctrl.pkt_waddr] <= line_rd_reg;
        end
        if (ctrl.pkt_re)
        begin
            pkt_rd_reg <= pkt_mem[ctrl.pkt_raddr];
        end
    end

    assign pkt_rdata = pkt_rd_reg;

endmodule

@@ src/crlf_line_receiver_two_slot.sv @@
`timescale 1ns / 1ps
// crlf_line_receiver_two_slot: top level of the crlf line receiver
// depends on lrx_pkg and lrx_mem
//
// usage
// - input channel (in_valid / in_stall) carries one request: op, rx_byte,
//   slot_sel, read_index; op 0 feeds a received byte, op 1 releases a slot,
//   op 2 reads one byte of a slot, op 3 only reports the slot flags
// - output channel (out_valid / out_stall) carries one result per request
// - bytes collect in a 256-entry line buffer; cr then lf completes the line
//   and it is copied byte by byte into slot a, else slot b, else dropped
// - states, accept to result valid: byte, release and no-op go straight
//   to the emit state, a slot read first waits in the read wait state for
//   the memory read, and a line completion that copies into a slot first
//   runs the copy loop, one byte per cycle from line buffer to packet store
// - one request in flight: in_stall is high from accept until the result
//   is loaded into the output register
// - the output register holds a result while out_stall is high; the next
//   request is still accepted and waits in the emit state until it drains
// - reset clears the line count, the cr flag, both slot busy flags and the
//   output valid; memory contents are undefined until written, no clear pass
module crlf_line_receiver_two_slot (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] op,
    input  logic [7:0] rx_byte,
    input  logic       slot_sel,
    input  logic [7:0] read_index,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic       line_done,
    output logic [7:0] line_length,
    output logic [1:0] slot_used,
    output logic       slot_a_full,
    output logic       slot_b_full,
    output logic       frame_error
);
    import lrx_pkg::*;

    // control state
    lrx_state_t         state_reg, state_next;
    logic [LINE_AW-1:0] line_count_reg, line_count_next;
    logic               cr_seen_reg, cr_seen_next;
    logic               slot_a_busy_reg, slot_a_busy_next;
    logic               slot_b_busy_reg, slot_b_busy_next;
    logic               out_valid_reg;

    // copy sequencer
    logic [LINE_AW-1:0] cp_idx_reg;
    logic [LINE_AW-1:0] cp_last_reg;
    logic               cp_slot_reg;
    logic               cp_wr_pending_reg;
    logic [LINE_AW-1:0] cp_wr_idx_reg;

    // pending result, held until the output register is free
    logic [7:0] res_read_data_reg;
    logic       res_done_reg;
    logic [7:0] res_len_reg;
    lrx_slot_t  res_used_reg;
    logic       res_a_full_reg;
    logic       res_b_full_reg;
    logic       res_ferr_reg;

    // output register
    logic [7:0] out_read_data_reg;
    logic       out_done_reg;
    logic [7:0] out_len_reg;
    lrx_slot_t  out_used_reg;
    logic       out_a_full_reg;
    logic       out_b_full_reg;
    logic       out_ferr_reg;

    lrx_mem_ctrl_t mem_ctrl;
    logic [7:0]    pkt_rdata;

    // request decode
    lrx_op_t op_in;
    logic    accept;
    logic    is_rx, is_release, is_read;
    logic    line_end, cr_bad, cr_start, data_byte, overflow;
    logic    to_a, to_b, copy_needed;
    logic    out_free;
    logic    cp_last_hit;
    lrx_slot_t used_now;

    assign op_in      = lrx_op_t'(op);
    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign is_rx      = (op_in == OP_RX);
    assign is_release = (op_in == OP_RELEASE);
    assign is_read    = (op_in == OP_READ);

    // byte classification against the cr flag
    assign line_end  = is_rx && cr_seen_reg && (rx_byte == CHAR_LF);
    assign cr_bad    = is_rx && cr_seen_reg && (rx_byte != CHAR_LF);
    assign cr_start  = is_rx && !cr_seen_reg && (rx_byte == CHAR_CR);
    assign data_byte = is_rx && !cr_seen_reg && (rx_byte != CHAR_CR);
    assign overflow  = data_byte && (line_count_reg == LINE_LAST);

    // slot a first, then slot b, else the line is dropped
    assign to_a        = line_end && !slot_a_busy_reg;
    assign to_b        = line_end && slot_a_busy_reg && !slot_b_busy_reg;
    assign copy_needed = (to_a || to_b) && (line_count_reg != '0);

    assign out_free    = !out_valid_reg || !out_stall;
    assign cp_last_hit = (cp_idx_reg == cp_last_reg);

    always_comb
    begin
        priority if (to_a)
            used_now = SLOT_A;
        else if (to_b)
            used_now = SLOT_B;
        else
            used_now = SLOT_NONE;
    end

    // architectural state updates of one request
    always_comb
    begin
        line_count_next  = line_count_reg;
        cr_seen_next     = cr_seen_reg;
        slot_a_busy_next = slot_a_busy_reg;
        slot_b_busy_next = slot_b_busy_reg;
        if (line_end || cr_bad)
        begin
            line_count_next = '0;
            cr_seen_next    = 1'b0;
        end
        if (cr_start)
        begin
            cr_seen_next = 1'b1;
        end
        if (data_byte)
        begin
            line_count_next = overflow ? '0 : line_count_reg + 1'b1;
        end
        if (to_a)
        begin
            slot_a_busy_next = 1'b1;
        end
        if (to_b)
        begin
            slot_b_busy_next = 1'b1;
        end
        if (is_release && !slot_sel)
        begin
            slot_a_busy_next = 1'b0;
        end
        if (is_release && slot_sel)
        begin
            slot_b_busy_next = 1'b0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (copy_needed)
                        state_next = ST_COPY;
                    else if (is_read)
                        state_next = ST_RD_WAIT;
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_COPY:
            begin
                if (cp_last_hit)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_RD_WAIT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory port controls
    always_comb
    begin
        mem_ctrl.line_we    = accept && data_byte;
        mem_ctrl.line_waddr = line_count_reg;
        mem_ctrl.line_wdata = rx_byte;
        mem_ctrl.line_re    = (state_reg == ST_COPY);
        mem_ctrl.line_raddr = cp_idx_reg;
        mem_ctrl.pkt_we     = cp_wr_pending_reg;
        mem_ctrl.pkt_waddr  = {cp_slot_reg, cp_wr_idx_reg};
        mem_ctrl.pkt_re     = accept && is_read;
        mem_ctrl.pkt_raddr  = {slot_sel, read_index[LINE_AW-1:0]};
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            line_count_reg    <= '0;
            cr_seen_reg       <= 1'b0;
            slot_a_busy_reg   <= 1'b0;
            slot_b_busy_reg   <= 1'b0;
            cp_wr_pending_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            cp_wr_pending_reg <= (state_reg == ST_COPY);
            if (accept)
            begin
                line_count_reg  <= line_count_next;
                cr_seen_reg     <= cr_seen_next;
                slot_a_busy_reg <= slot_a_busy_next;
                slot_b_busy_reg <= slot_b_busy_next;
            end
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // copy counters and result payload
    always_ff @(posedge clk)
    begin
        cp_wr_idx_reg <= cp_idx_reg;
        if (accept)
        begin
            cp_idx_reg        <= '0;
            cp_last_reg       <= line_count_reg - 1'b1;
            cp_slot_reg       <= to_b;
            res_read_data_reg <= 8'd0;
            res_done_reg      <= line_end;
            res_len_reg       <= line_end ? 8'(line_count_reg) : 8'd0;
            res_used_reg      <= used_now;
            res_a_full_reg    <= slot_a_busy_next;
            res_b_full_reg    <= slot_b_busy_next;
            res_ferr_reg      <= cr_bad || overflow;
        end
        else if (state_reg == ST_COPY)
        begin
            cp_idx_reg <= cp_idx_reg + 1'b1;
        end
        if (state_reg == ST_RD_WAIT)
        begin
            res_read_data_reg <= pkt_rdata;
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            out_read_data_reg <= res_read_data_reg;
            out_done_reg      <= res_done_reg;
            out_len_reg       <= res_len_reg;
            out_used_reg      <= res_used_reg;
            out_a_full_reg    <= res_a_full_reg;
            out_b_full_reg    <= res_b_full_reg;
            out_ferr_reg      <= res_ferr_reg;
        end
    end

    // line buffer read data feeds the packet store inside the memory block
    lrx_mem u_mem (
        .clk        (clk),
        .ctrl       (mem_ctrl),
        .pkt_rdata  (pkt_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign read_data   = out_read_data_reg;
    assign line_done   = out_done_reg;
    assign line_length = out_len_reg;
    assign slot_used   = out_used_reg;
    assign slot_a_full = out_a_full_reg;
    assign slot_b_full = out_b_full_reg;
    assign frame_error = out_ferr_reg;

endmodule

@@ verif/crlf_line_receiver_two_slot_tb.sv @@
`timescale 1ns / 1ps
// crlf_line_receiver_two_slot_tb: self-checking bench for the crlf line receiver
// depends on lrx_pkg and crlf_line_receiver_two_slot; stimulus, prediction
// and checking all live here, nothing is read from outside
module crlf_line_receiver_two_slot_tb;

    import lrx_pkg::*;

    localparam int TOTAL_REQS  = 950;
    localparam int CYCLE_LIMIT = 1_500_000;
    // longest copy plus the longest output stall, with margin
    localparam int QUIET_CYCLES = 400;

    // one request as the sender presents it
    typedef struct {
        lrx_op_t    op;
        logic [7:0] rx_byte;
        logic       slot_sel;
        logic [7:0] read_index;
        bit         drain_first;   // hold until every result is back
    } rx_req_t;

    // one result as the receiver should see it
    typedef struct packed {
        logic [7:0] read_data;
        logic       line_done;
        logic [7:0] line_length;
        lrx_slot_t  slot_used;
        logic       slot_a_full;
        logic       slot_b_full;
        logic       frame_error;
    } line_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] op;
    logic [7:0] rx_byte;
    logic       slot_sel;
    logic [7:0] read_index;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] read_data;
    logic       line_done;
    logic [7:0] line_length;
    logic [1:0] slot_used;
    logic       slot_a_full;
    logic       slot_b_full;
    logic       frame_error;

    crlf_line_receiver_two_slot DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .rx_byte     (rx_byte),
        .slot_sel    (slot_sel),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .line_done   (line_done),
        .line_length (line_length),
        .slot_used   (slot_used),
        .slot_a_full (slot_a_full),
        .slot_b_full (slot_b_full),
        .frame_error (frame_error)
    );

    // clock and the single reset at the start of the run
    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // line receiver shadow: line buffer, cr flag, two slots and busy flags
    // ------------------------------------------------------------------
    logic [7:0] line_buf [LINE_DEPTH];
    int         line_fill;
    bit         cr_pending;
    logic [7:0] slot_mem [2][LINE_DEPTH];
    bit         slot_written [2][LINE_DEPTH];   // bytes a read may touch
    bit         busy_a;
    bit         busy_b;

    initial
    begin
        line_fill  = 0;
        cr_pending = 1'b0;
        busy_a     = 1'b0;
        busy_b     = 1'b0;
        for (int s = 0; s < 2; s++)
            for (int i = 0; i < LINE_DEPTH; i++)
                slot_written[s][i] = 1'b0;
    end

    // move the gathered line into a slot and mark those bytes readable
    function automatic void store_line(input int slot);
        for (int i = 0; i < line_fill; i++)
        begin
            slot_mem[slot][i]     = line_buf[i];
            slot_written[slot][i] = 1'b1;
        end
    endfunction

    // apply one accepted request to the shadow and return its result
    function automatic line_result_t receive_request(input rx_req_t req);
        line_result_t res;
        res.read_data   = 8'd0;
        res.line_done   = 1'b0;
        res.line_length = 8'd0;
        res.slot_used   = SLOT_NONE;
        res.frame_error = 1'b0;
        case (req.op)
            OP_RX:
            begin
                if (cr_pending)
                begin
                    // cr then lf closes the line; cr then anything else
                    // throws the line and that byte away
                    if (req.rx_byte == CHAR_LF)
                    begin
                        res.line_done   = 1'b1;
                        res.line_length = line_fill[7:0];
                        if (!busy_a)
                        begin
                            store_line(0);
                            busy_a        = 1'b1;
                            res.slot_used = SLOT_A;
                        end
                        else if (!busy_b)
                        begin
                            store_line(1);
                            busy_b        = 1'b1;
                            res.slot_used = SLOT_B;
                        end
                    end
                    else
                        res.frame_error = 1'b1;
                    line_fill  = 0;
                    cr_pending = 1'b0;
                end
                else if (req.rx_byte == CHAR_CR)
                    cr_pending = 1'b1;
                else
                begin
                    line_buf[line_fill] = req.rx_byte;
                    line_fill++;
                    // a full buffer drops the line and starts over
                    if (line_fill >= LINE_DEPTH)
                    begin
                        line_fill       = 0;
                        res.frame_error = 1'b1;
                    end
                end
            end
            OP_RELEASE:
            begin
                if (req.slot_sel == 1'b0)
                    busy_a = 1'b0;
                else
                    busy_b = 1'b0;
            end
            OP_READ:
                res.read_data = slot_mem[req.slot_sel][req.read_index];
            default: ;
        endcase
        res.slot_a_full = busy_a;
        res.slot_b_full = busy_b;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // queues and counters shared by generator, driver and monitor
    // ------------------------------------------------------------------
    rx_req_t      pending_reqs[$];
    line_result_t expected_results[$];
    int           n_queued;
    int           n_accepted;
    int           n_errors;
    int           cycles;

    initial
    begin
        n_queued = 0;
        n_errors = 0;
    end

    // ------------------------------------------------------------------
    // driver: sends requests in bursts with random gaps in between
    // ------------------------------------------------------------------
    rx_req_t cur_req;
    int      burst_left;
    int      gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            op         <= OP_NONE;
            rx_byte    <= 8'd0;
            slot_sel   <= 1'b0;
            read_index <= 8'd0;
            burst_left <= 0;
            gap_left   <= 0;
            n_accepted <= 0;
        end
        else
        begin
            // the request on the bus goes through: predict its result now
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(receive_request(cur_req));
                n_accepted <= n_accepted + 1;
            end
            // bus is free for the next request (or stays as it is)
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain_first && expected_results.size() != 0))
                begin
                    cur_req    = pending_reqs.pop_front();
                    in_valid   <= 1'b1;
                    op         <= cur_req.op;
                    rx_byte    <= cur_req.rx_byte;
                    slot_sel   <= cur_req.slot_sel;
                    read_index <= cur_req.read_index;
                    if (burst_left <= 1)
                    begin
                        // new burst; a third of them follow with no gap at all
                        burst_left <= $urandom_range(1, 16);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: compares each result with the oldest prediction
    // ------------------------------------------------------------------
    line_result_t want;
    int           stall_mode;
    int           mode_left;

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            n_errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode <= 0;
            mode_left  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request waiting for it");
                    n_errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_data",   int'(want.read_data),   int'(read_data));
                    check_field("line_done",   int'(want.line_done),   int'(line_done));
                    check_field("line_length", int'(want.line_length), int'(line_length));
                    check_field("slot_used",   int'(want.slot_used),   int'(slot_used));
                    check_field("slot_a_full", int'(want.slot_a_full), int'(slot_a_full));
                    check_field("slot_b_full", int'(want.slot_b_full), int'(slot_b_full));
                    check_field("frame_error", int'(want.frame_error), int'(frame_error));
                end
            end
            // stall pattern: open stretches, coin-flip stretches and long
            // holds that release at the end of the stretch
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(10, 60);
                out_stall  <= 1'b0;
            end
            else
            begin
                mode_left <= mode_left - 1;
                case (stall_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= 1'($urandom_range(0, 1));
                    default: out_stall <= (mode_left > 5);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // request generation
    // ------------------------------------------------------------------
    task automatic queue_req(input lrx_op_t o, input logic [7:0] b, input logic s,
                             input logic [7:0] idx, input bit drain);
        rx_req_t req;
        req.op          = o;
        req.rx_byte     = b;
        req.slot_sel    = s;
        req.read_index  = idx;
        req.drain_first = drain;
        pending_reqs.push_back(req);
        n_queued++;
    endtask

    task automatic queue_byte(input logic [7:0] b);
        queue_req(OP_RX, b, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
    endtask

    // any line byte except cr; lf alone is plain payload
    function automatic logic [7:0] payload_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CHAR_CR)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic queue_line(input int len);
        for (int i = 0; i < len; i++)
            queue_byte(payload_byte());
        queue_byte(CHAR_CR);
        queue_byte(CHAR_LF);
    endtask

    // let the shadow catch up with everything queued so far
    task automatic wait_accepted();
        while (n_accepted != n_queued)
            @(posedge clk);
    endtask

    // random slot byte that has been written; -1 when the slot has none
    function automatic int pick_index(input int slot);
        int start;
        start = $urandom_range(0, LINE_DEPTH - 1);
        for (int k = 0; k < LINE_DEPTH; k++)
            if (slot_written[slot][(start + k) % LINE_DEPTH])
                return (start + k) % LINE_DEPTH;
        return -1;
    endfunction

    // reads only ever touch bytes some line has already filled in
    task automatic queue_reads(input int count);
        int s;
        int idx;
        wait_accepted();
        repeat (count)
        begin
            s   = $urandom_range(0, 1);
            idx = pick_index(s);
            if (idx < 0)
            begin
                s   = 1 - s;
                idx = pick_index(s);
            end
            if (idx >= 0)
                queue_req(OP_READ, 8'($urandom_range(0, 255)), s[0], idx[7:0], 1'b0);
        end
    endtask

    task automatic queue_noise();
        lrx_op_t o;
        o = lrx_op_t'(2'($urandom_range(0, 3)));
        if (o == OP_READ)
            o = OP_NONE;
        queue_req(o, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), 1'b0);
    endtask

    initial
    begin
        int pick;
        while (rst_n !== 1'b1)
            @(posedge clk);

        // directed: idle op, release of a free slot, fill a, fill b with
        // an empty line, then a drop with both slots taken
        queue_req(OP_NONE, 8'hff, 1'b1, 8'hff, 1'b0);
        queue_req(OP_RELEASE, 8'h00, 1'b0, 8'h00, 1'b0);
        queue_byte(8'h00);
        queue_byte(8'hff);
        queue_byte(CHAR_LF);
        queue_byte(CHAR_CR);
        queue_byte(CHAR_LF);
        queue_reads(3);
        queue_line(0);
        queue_line(1);
        // cr followed by a plain byte, and cr followed by another cr
        queue_byte(CHAR_CR);
        queue_byte(8'h41);
        queue_byte(CHAR_CR);
        queue_byte(CHAR_CR);
        // release b twice (second is a no-op), release a after a full drain
        queue_req(OP_RELEASE, 8'h00, 1'b1, 8'h00, 1'b0);
        queue_req(OP_RELEASE, 8'hff, 1'b1, 8'hff, 1'b0);
        queue_req(OP_RELEASE, 8'h00, 1'b0, 8'h00, 1'b1);
        // longest legal line goes to a, so reads can reach indices 0 to 254
        queue_line(LINE_DEPTH - 1);
        queue_reads(4);
        // overflow: a full buffer of bytes, then a short line after restart
        for (int i = 0; i < LINE_DEPTH; i++)
            queue_byte(payload_byte());
        queue_line(2);
        queue_reads(4);

        // random mix, weighted toward well-formed lines
        while (n_queued < TOTAL_REQS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                queue_line(($urandom_range(0, 5) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(0, 12));
            else if (pick < 60)
                queue_req(OP_RELEASE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)), $urandom_range(0, 29) == 0);
            else if (pick < 75)
                queue_reads($urandom_range(1, 4));
            else if (pick < 83)
            begin
                // broken line: cr followed by anything but lf
                repeat ($urandom_range(0, 6))
                    queue_byte(payload_byte());
                queue_byte(CHAR_CR);
                queue_byte(($urandom_range(0, 3) == 0) ? CHAR_CR
                                                       : 8'(8'h41 + $urandom_range(0, 25)));
            end
            else if (pick < 95)
                queue_noise();
            else if (pick < 98)
                queue_req(OP_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)), 1'b0);
            else
                queue_line($urandom_range(60, LINE_DEPTH - 1));
        end

        // drain: all accepted, all results back, then a quiet stretch
        wait_accepted();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("crlf_line_receiver_two_slot_tb passed");
        else
            $display("crlf_line_receiver_two_slot_tb failed");
        $finish;
    end

    // hang guard
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("crlf_line_receiver_two_slot_tb failed");
            $finish;
        end
    end

endmodule
